### hw/rtl/jsu_pkg.sv
// Shared types, character constants and helpers for the JSON string unescaper.
// Used by jsu_decode, json_string_unescape and jsu_checker.
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_TEXT = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_QUOTE = 2'd1;
  localparam logic [1:0] ERR_ESC   = 2'd2;

  localparam logic [7:0] CH_END       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_VT        = 8'h0b;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LOWER_N   = 8'h6e;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_V   = 8'h76;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;
  localparam logic [7:0] CH_DIGIT_0   = 8'h30;
  localparam logic [7:0] CH_DIGIT_9   = 8'h39;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_F   = 8'h46;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] code;
  } jsu_result_t;

  // Bit 4 set means the byte is not a hex digit; bits 3:0 hold the digit value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] diff;
    begin
      diff = 8'd0;
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
        diff = c - CH_DIGIT_0;
        hex_value = {1'b0, diff[3:0]};
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
        diff = c - CH_LOWER_A + 8'd10;
        hex_value = {1'b0, diff[3:0]};
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
        diff = c - CH_UPPER_A + 8'd10;
        hex_value = {1'b0, diff[3:0]};
      end else begin
        hex_value = 5'b10000;
      end
    end
  endfunction

endpackage

### hw/rtl/jsu_decode.sv
// Combinational next-state and result logic for one text byte.
// Depends on jsu_pkg for the phase type, character codes and hex_value.
`timescale 1ns / 1ps

module jsu_decode (
  input  jsu_pkg::phase_t     phase,
  input  logic [3:0]          high_nibble,
  input  logic [7:0]          in_byte,
  output jsu_pkg::phase_t     phase_next,
  output logic [3:0]          high_nibble_next,
  output jsu_pkg::jsu_result_t result
);
  import jsu_pkg::*;

  logic [4:0] hex;
  logic       is_space;

  assign hex      = hex_value(in_byte);
  assign is_space = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    result           = '{valid: 1'b0, kind: KIND_DATA, data: 8'd0, code: ERR_NONE};
    unique case (phase)
      PH_WAIT: begin
        if (is_space) begin
          phase_next = PH_WAIT;
        end else if (in_byte == CH_QUOTE) begin
          phase_next = PH_TEXT;
        end else begin
          result = '{valid: 1'b1, kind: KIND_ERROR, data: 8'd0, code: ERR_QUOTE};
        end
      end
      PH_TEXT: begin
        if (in_byte == CH_END) begin
          phase_next = PH_WAIT;
          result = '{valid: 1'b1, kind: KIND_ERROR, data: 8'd0, code: ERR_QUOTE};
        end else if (in_byte == CH_QUOTE) begin
          phase_next = PH_WAIT;
          result = '{valid: 1'b1, kind: KIND_CLOSE, data: 8'd0, code: ERR_NONE};
        end else if (in_byte == CH_BACKSLASH) begin
          phase_next = PH_ESC;
        end else begin
          result = '{valid: 1'b1, kind: KIND_DATA, data: in_byte, code: ERR_NONE};
        end
      end
      PH_ESC: begin
        phase_next = PH_TEXT;
        result = '{valid: 1'b1, kind: KIND_DATA, data: 8'd0, code: ERR_NONE};
        unique case (in_byte)
          CH_BACKSLASH: result.data = CH_BACKSLASH;
          CH_LOWER_N:   result.data = CH_LF;
          CH_LOWER_R:   result.data = CH_CR;
          CH_LOWER_T:   result.data = CH_TAB;
          CH_LOWER_B:   result.data = CH_BS;
          CH_LOWER_V:   result.data = CH_VT;
          CH_LOWER_X: begin
            phase_next   = PH_HEX1;
            result.valid = 1'b0;
          end
          default: begin
            phase_next = PH_WAIT;
            result = '{valid: 1'b1, kind: KIND_ERROR, data: 8'd0, code: ERR_ESC};
          end
        endcase
      end
      PH_HEX1: begin
        if (hex[4]) begin
          phase_next = PH_WAIT;
          result = '{valid: 1'b1, kind: KIND_ERROR, data: 8'd0, code: ERR_ESC};
        end else begin
          phase_next       = PH_HEX2;
          high_nibble_next = hex[3:0];
        end
      end
      PH_HEX2: begin
        if (hex[4]) begin
          phase_next = PH_WAIT;
          result = '{valid: 1'b1, kind: KIND_ERROR, data: 8'd0, code: ERR_ESC};
        end else begin
          phase_next = PH_TEXT;
          result = '{valid: 1'b1, kind: KIND_DATA, data: {high_nibble, hex[3:0]},
                     code: ERR_NONE};
        end
      end
      default: begin
        // Unused phase codes fall back to looking for a string.
        phase_next = PH_WAIT;
      end
    endcase
  end

endmodule

### hw/rtl/json_string_unescape.sv
// Top level of the JSON string unescaper: input register, decode, result register.
// Depends on jsu_pkg and jsu_decode.
`timescale 1ns / 1ps

// One text byte is taken per word and the block sustains one byte per clock
// while out_stall is low. A byte waits in the input register, is decoded
// against the parse phase, and its result (if any) is loaded into the result
// register, from which it is offered. The input register keeps accepting
// while a result waits, as long as it is itself empty or moving on.
// Whitespace before a string, the opening quote, a backslash, an x and
// the first hex digit produce no result word. After an error or a closed
// string the block looks for the next opening quote.
module json_string_unescape (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic [1:0] error_code
);
  import jsu_pkg::*;

  logic        hold_valid;
  logic [7:0]  hold_byte;
  phase_t      phase;
  phase_t      phase_next;
  logic [3:0]  high_nibble;
  logic [3:0]  high_nibble_next;
  jsu_result_t result;
  logic        advance;

  // The held byte moves on whenever the result register is free or draining.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = hold_valid && !advance;

  jsu_decode u_decode (
    .phase            (phase),
    .high_nibble      (high_nibble),
    .in_byte          (hold_byte),
    .phase_next       (phase_next),
    .high_nibble_next (high_nibble_next),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid  <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= PH_WAIT;
      high_nibble <= 4'd0;
    end else begin
      if (!in_stall) begin
        hold_valid <= in_valid;
      end
      if (hold_valid && advance) begin
        phase       <= phase_next;
        high_nibble <= high_nibble_next;
      end
      if (advance) begin
        out_valid <= hold_valid && result.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= in_byte;
    end
    if (advance && hold_valid && result.valid) begin
      kind       <= result.kind;
      out_byte   <= result.data;
      error_code <= result.code;
    end
  end

endmodule

### hw/rtl/jsu_checker.sv
// Port-level assertions for json_string_unescape, attached with a bind.
// Depends on jsu_pkg for the kind and error codes.
`timescale 1ns / 1ps

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic [1:0] error_code
);
  import jsu_pkg::*;

  // A result held against a stall stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte)
      && $stable(error_code))
    else $error("result changed while stalled");

  // Only data words carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> out_byte == 8'd0)
    else $error("byte set on a non-data word");

  // An error code appears exactly on error words.
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match kind");

  // With no byte accepted, followed by a sample with again no byte accepted and
  // no word pending, the input register is empty, so no word can appear next.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall) ##1 (!out_valid && !(in_valid && !in_stall))
      |=> !out_valid)
    else $error("result appeared without an accepted byte");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .out_byte   (out_byte),
  .error_code (error_code)
);

### tb/sv/tb.sv
// Self-checking testbench for json_string_unescape: a short directed table, then random
// well-formed, broken and noise strings, checked word by word against a local decoder model.
// Depends on jsu_pkg and the json_string_unescape RTL.
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] code;
  } word_t;

  // One stimulus row. Where typed is set, has/kind/data/code give the expected
  // output word directly; otherwise the decoder model supplies it.
  typedef struct packed {
    logic [7:0] text;
    logic       typed;
    logic       has;
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] code;
  } stim_row_t;

  localparam int RandomItems   = 1500;
  localparam int QuietTail     = 200;
  localparam int HoldStart     = 500;
  localparam int HoldCycles    = 60;
  localparam int WatchdogLimit = 2000;
  localparam int MaxShown      = 10;
  localparam int DirRows       = 28;

  localparam logic [7:0] SimpleEsc [6] = '{CH_BACKSLASH, CH_LOWER_N, CH_LOWER_R,
                                           CH_LOWER_T, CH_LOWER_B, CH_LOWER_V};

  localparam stim_row_t Directed [DirRows] = '{
    '{CH_END,       1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_QUOTE},
    '{8'hff,        1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_QUOTE},
    '{CH_SPACE,     1'b1, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_CR,        1'b1, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_QUOTE,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{8'hff,        1'b1, 1'b1, KIND_DATA,  8'hff, ERR_NONE},
    '{CH_END,       1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_QUOTE},
    '{CH_QUOTE,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_BACKSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_QUOTE,     1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_ESC},
    '{CH_QUOTE,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_BACKSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_END,       1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_ESC},
    '{CH_QUOTE,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_BACKSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_LOWER_X,   1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{8'h67,        1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_ESC},
    '{CH_QUOTE,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_BACKSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_LOWER_X,   1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_LOWER_F,   1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_DIGIT_9,   1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_BACKSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_LOWER_X,   1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_UPPER_A,   1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{8'h2f,        1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_ESC},
    '{CH_QUOTE,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{CH_QUOTE,     1'b1, 1'b1, KIND_CLOSE, 8'h00, ERR_NONE}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [1:0] error_code;

  always #1 clk = ~clk;

  json_string_unescape DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .out_byte   (out_byte),
    .error_code (error_code)
  );

  stim_row_t stim_q[$];
  word_t     expected_words[$];
  int        sent_idx = 0;
  int        quiet_from = 0;
  int        errors = 0;
  int        shown = 0;
  logic      holding = 1'b0;

  // Decoder model state.
  phase_t     dec_phase = PH_WAIT;
  logic [3:0] dec_nibble = 4'h0;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return int'(c) - int'(CH_DIGIT_0);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c) - int'(CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c) - int'(CH_UPPER_A) + 10;
    return -1;
  endfunction

  // Advances the decoder model by one byte; returns 1 when the byte yields a word.
  function automatic bit unescape_step(input logic [7:0] c, output word_t w);
    int h;
    bit hit;
    hit = 1'b0;
    w = '{KIND_DATA, 8'h00, ERR_NONE};
    case (dec_phase)
      PH_WAIT: begin
        if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
          if (c == CH_QUOTE) begin
            dec_phase = PH_TEXT;
          end else begin
            w = '{KIND_ERROR, 8'h00, ERR_QUOTE};
            hit = 1'b1;
          end
        end
      end
      PH_TEXT: begin
        if (c == CH_END) begin
          dec_phase = PH_WAIT;
          w = '{KIND_ERROR, 8'h00, ERR_QUOTE};
          hit = 1'b1;
        end else if (c == CH_QUOTE) begin
          dec_phase = PH_WAIT;
          w = '{KIND_CLOSE, 8'h00, ERR_NONE};
          hit = 1'b1;
        end else if (c == CH_BACKSLASH) begin
          dec_phase = PH_ESC;
        end else begin
          w = '{KIND_DATA, c, ERR_NONE};
          hit = 1'b1;
        end
      end
      PH_ESC: begin
        dec_phase = PH_TEXT;
        hit = 1'b1;
        case (c)
          CH_BACKSLASH: w = '{KIND_DATA, CH_BACKSLASH, ERR_NONE};
          CH_LOWER_N:   w = '{KIND_DATA, CH_LF, ERR_NONE};
          CH_LOWER_R:   w = '{KIND_DATA, CH_CR, ERR_NONE};
          CH_LOWER_T:   w = '{KIND_DATA, CH_TAB, ERR_NONE};
          CH_LOWER_B:   w = '{KIND_DATA, CH_BS, ERR_NONE};
          CH_LOWER_V:   w = '{KIND_DATA, CH_VT, ERR_NONE};
          CH_LOWER_X: begin
            dec_phase = PH_HEX1;
            hit = 1'b0;
          end
          default: begin
            dec_phase = PH_WAIT;
            w = '{KIND_ERROR, 8'h00, ERR_ESC};
          end
        endcase
      end
      PH_HEX1: begin
        h = hex_digit(c);
        if (h < 0) begin
          dec_phase = PH_WAIT;
          w = '{KIND_ERROR, 8'h00, ERR_ESC};
          hit = 1'b1;
        end else begin
          dec_nibble = 4'(h);
          dec_phase = PH_HEX2;
        end
      end
      PH_HEX2: begin
        h = hex_digit(c);
        hit = 1'b1;
        if (h < 0) begin
          dec_phase = PH_WAIT;
          w = '{KIND_ERROR, 8'h00, ERR_ESC};
        end else begin
          dec_phase = PH_TEXT;
          w = '{KIND_DATA, {dec_nibble, 4'(h)}, ERR_NONE};
        end
      end
      default: dec_phase = PH_WAIT;
    endcase
    return hit;
  endfunction

  task automatic append_row(input stim_row_t row);
    stim_q.insert(stim_q.size(), row);
  endtask

  task automatic append_word(input word_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic push_byte(input logic [7:0] b);
    append_row('{b, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_NONE});
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BACKSLASH);
    return b;
  endfunction

  function automatic logic [7:0] pick_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_DIGIT_0 + 8'(v);
    if ($urandom_range(0, 1) == 0) return CH_LOWER_A + 8'(v - 10);
    return CH_UPPER_A + 8'(v - 10);
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
    return b;
  endfunction

  // String contents: plain bytes, simple escapes and hex escapes.
  task automatic add_body(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        push_byte(pick_plain());
      end else if (r < 85) begin
        push_byte(CH_BACKSLASH);
        push_byte(SimpleEsc[$urandom_range(0, 5)]);
      end else begin
        push_byte(CH_BACKSLASH);
        push_byte(CH_LOWER_X);
        push_byte(pick_hex_char());
        push_byte(pick_hex_char());
      end
    end
  endtask

  task automatic report_fail(input string msg);
    errors++;
    if (shown < MaxShown) begin
      shown++;
      $display("MISMATCH: %s", msg);
    end
  endtask

  // Model update on every accepted input word, check on every accepted output word.
  always @(posedge clk) begin
    word_t     w;
    word_t     want;
    word_t     got;
    bit        hit;
    stim_row_t row;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        row = stim_q[sent_idx];
        hit = unescape_step(in_byte, w);
        if (row.typed) begin
          hit = row.has;
          w = '{row.kind, row.data, row.code};
        end
        if (hit) append_word(w);
        sent_idx <= sent_idx + 1;
      end
      if (out_valid && !out_stall) begin
        got = '{kind, out_byte, error_code};
        if (expected_words.size() == 0) begin
          report_fail($sformatf("unexpected word kind=%0d byte=%02h code=%0d",
                                kind, out_byte, error_code));
        end else begin
          want = expected_words.pop_front();
          if (want !== got) begin
            report_fail($sformatf(
              "expected kind=%0d byte=%02h code=%0d, got kind=%0d byte=%02h code=%0d",
              want.kind, want.data, want.code, kind, out_byte, error_code));
          end
        end
      end
    end
  end

  // Sender: offers stimulus bytes in order, with random idle bursts.
  always @(posedge clk) begin
    int nxt;
    int idle_left;
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else if (!(in_valid && in_stall)) begin
      nxt = sent_idx + ((in_valid && !in_stall) ? 1 : 0);
      if (idle_left > 0) begin
        in_valid <= 1'b0;
        idle_left--;
      end else if (nxt < stim_q.size()) begin
        if (nxt < quiet_from && !holding && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          idle_left = $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b1;
          in_byte <= stim_q[nxt].text;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off so the block fills up.
  always @(posedge clk) begin
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (!hold_done && sent_idx >= HoldStart) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      holding <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      holding <= 1'b0;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (sent_idx < quiet_from && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int         sel;
    int         target;
    bit         bad;
    logic [7:0] b;
    foreach (Directed[i]) append_row(Directed[i]);
    target = DirRows + RandomItems;
    // Mostly well-formed strings; the rest are strings cut off by an error, and noise.
    while (stim_q.size() < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        repeat ($urandom_range(0, 2)) begin
          push_byte(($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
        end
        push_byte(CH_QUOTE);
        add_body($urandom_range(0, 10));
        push_byte(CH_QUOTE);
      end else if (sel < 90) begin
        push_byte(CH_QUOTE);
        add_body($urandom_range(0, 4));
        case ($urandom_range(0, 4))
          0: push_byte(CH_END);
          1: begin
            do begin
              b = 8'($urandom_range(0, 255));
              bad = (b != CH_LOWER_X);
              foreach (SimpleEsc[k]) if (b == SimpleEsc[k]) bad = 1'b0;
            end while (!bad);
            push_byte(CH_BACKSLASH);
            push_byte(b);
          end
          2: begin
            push_byte(CH_BACKSLASH);
            push_byte(CH_END);
          end
          3: begin
            push_byte(CH_BACKSLASH);
            push_byte(CH_LOWER_X);
            push_byte(pick_non_hex());
          end
          default: begin
            push_byte(CH_BACKSLASH);
            push_byte(CH_LOWER_X);
            push_byte(pick_hex_char());
            push_byte(pick_non_hex());
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end
    end
    quiet_from = stim_q.size() - QuietTail;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (sent_idx < stim_q.size() || expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Ends the run when no word has moved on either side for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    @(negedge rst);
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
